>>> rtl/core/input_restricted_deque_assert.svh
// Assertion macros for the deque core. Both sample on clk and disable on rst_n.
`ifndef INPUT_RESTRICTED_DEQUE_ASSERT_SVH
`define INPUT_RESTRICTED_DEQUE_ASSERT_SVH

`ifndef SYNTHESIS
`define IRD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ird assertion failed");
`define IRD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ird assertion failed");
`else
`define IRD_ASSERT_IMP(lbl, ante, cons)
`define IRD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> rtl/core/ird_pkg.sv
`timescale 1ns / 1ps

package ird_pkg;

  localparam int DEPTH  = 16;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = PTR_W + 2;
  localparam int WORD_W = 32;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(16);
  localparam logic [WORD_W-1:0] NEG_ONE   = '1;

  localparam logic [1:0] FN_INSERT    = 2'd0;
  localparam logic [1:0] FN_POP_FRONT = 2'd1;
  localparam logic [1:0] FN_POP_REAR  = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]               func;
    logic signed [WORD_W-1:0] value;
  } ird_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] popped;
    logic [1:0]               status;
    logic                     is_full;
    logic                     is_empty;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
  } ird_out_t;

  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [WORD_W-1:0] wdata;
    logic [PTR_W-1:0]  raddr_a;
    logic [PTR_W-1:0]  raddr_b;
  } ird_mem_req_t;

  // Ring slot at a given distance from base; off never exceeds DEPTH.
  function automatic logic [PTR_W-1:0] slot_at(logic [PTR_W-1:0] base,
                                                logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

>>> rtl/core/ird_ram.sv
`timescale 1ns / 1ps

module ird_ram (
  input  logic                          clk,
  input  ird_pkg::ird_mem_req_t         req,
  output logic [ird_pkg::WORD_W-1:0]    rd_a,
  output logic [ird_pkg::WORD_W-1:0]    rd_b
);
  import ird_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_a_r;
  logic [WORD_W-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_a_r <= mem[req.raddr_a];
    rd_b_r <= mem[req.raddr_b];
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

>>> rtl/core/ird_ctrl.sv
`timescale 1ns / 1ps

module ird_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  ird_pkg::ird_in_t            in_item,
  input  logic [ird_pkg::CAP_W-1:0]   capacity,
  output logic                        busy,
  output logic                        out_strobe,
  output ird_pkg::ird_out_t           out_item,
  output ird_pkg::ird_mem_req_t       mem_req,
  input  logic [ird_pkg::WORD_W-1:0]  rd_a,
  input  logic [ird_pkg::WORD_W-1:0]  rd_b
);
  import ird_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_READ, S_RESP} state_t;

  state_t             state_r;
  ird_in_t            item_r;
  logic [PTR_W-1:0]   front_r;
  logic [CNT_W-1:0]   occ_r;
  logic [WORD_W-1:0]  popped_r;
  logic [1:0]         status_r;
  logic [WORD_W-1:0]  front_val_r;
  logic [WORD_W-1:0]  rear_val_r;

  logic [CNT_W-1:0]   eff_cap;
  logic               full;
  logic               empty;
  logic [PTR_W-1:0]   tail_slot;
  logic [PTR_W-1:0]   last_slot;

  assign eff_cap   = (int'(capacity) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(capacity);
  assign full      = (occ_r >= eff_cap);
  assign empty     = (occ_r == '0);
  assign tail_slot = slot_at(front_r, occ_r);
  assign last_slot = empty ? front_r : slot_at(front_r, occ_r - CNT_W'(1));

  always_comb begin
    mem_req         = '0;
    mem_req.waddr   = tail_slot;
    mem_req.wdata   = item_r.value;
    mem_req.raddr_a = front_r;
    mem_req.raddr_b = last_slot;
    mem_req.we      = (state_r == S_EXEC) && (item_r.func == FN_INSERT) && !full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      front_r <= '0;
      occ_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            item_r  <= in_item;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          popped_r <= NEG_ONE;
          status_r <= ST_DONE;
          unique case (item_r.func)
            FN_INSERT: begin
              if (full) begin
                status_r <= ST_FULL;
              end else begin
                occ_r <= occ_r + CNT_W'(1);
              end
            end
            FN_POP_FRONT: begin
              if (empty) begin
                status_r <= ST_EMPTY;
              end else begin
                popped_r <= front_val_r;
                front_r  <= slot_at(front_r, CNT_W'(1));
                occ_r    <= occ_r - CNT_W'(1);
              end
            end
            FN_POP_REAR: begin
              if (empty) begin
                status_r <= ST_EMPTY;
              end else begin
                popped_r <= rear_val_r;
                occ_r    <= occ_r - CNT_W'(1);
              end
            end
            default: begin
            end
          endcase
          state_r <= S_READ;
        end
        S_READ: begin
          // read of the new end slots is in flight
          state_r <= S_RESP;
        end
        S_RESP: begin
          front_val_r <= rd_a;
          rear_val_r  <= rd_b;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = (state_r == S_RESP);

  always_comb begin
    out_item             = '0;
    out_item.popped      = popped_r;
    out_item.status      = status_r;
    out_item.is_full     = full;
    out_item.is_empty    = empty;
    out_item.front_value = empty ? NEG_ONE : rd_a;
    out_item.rear_value  = empty ? NEG_ONE : rd_b;
  end

endmodule

>>> rtl/core/input_restricted_deque.sv
`timescale 1ns / 1ps
// Channel   Transfer when            Payload
// input     start && !busy           in_item   (func, value)
// result    out_strobe               out_item  (popped .. rear_value)
// config    cfg_we                   cfg_wdata (capacity)
//
// An item passes through the execute, ring memory read and result states, then returns to idle;
// the ring memory, with a single write port and a registered read, sets this order.
// The result shows on out_strobe in S_RESP, after the S_EXEC and S_READ states that follow the start transfer.
// busy is high in S_EXEC, S_READ and S_RESP and low only while idle.
// Reset (rst_n low, synchronous) empties the queue and sets capacity to 16.
// The receiver cannot stall; each result stands for one cycle only.

module input_restricted_deque (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  ird_pkg::ird_in_t            in_item,
  output logic                        out_strobe,
  output ird_pkg::ird_out_t           out_item,
  input  logic                        cfg_we,
  input  logic [ird_pkg::CAP_W-1:0]   cfg_wdata
);
  import ird_pkg::*;

  `include "input_restricted_deque_assert.svh"

  logic [CAP_W-1:0]   capacity_r;
  ird_mem_req_t       mem_req;
  logic [WORD_W-1:0]  rd_a;
  logic [WORD_W-1:0]  rd_b;
  logic               ends_neg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_we) begin
      capacity_r <= cfg_wdata;
    end
  end

  ird_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_item    (in_item),
    .capacity   (capacity_r),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .mem_req    (mem_req),
    .rd_a       (rd_a),
    .rd_b       (rd_b)
  );

  ird_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rd_a  (rd_a),
    .rd_b  (rd_b)
  );

  assign ends_neg = (out_item.front_value == NEG_ONE) && (out_item.rear_value == NEG_ONE);

  `IRD_ASSERT_IMP(a_result_latency, start && !busy, ##3 out_strobe)
  `IRD_ASSERT_IMP(a_strobe_busy, out_strobe, busy)
  `IRD_ASSERT_IMP(a_refused_full, out_strobe && out_item.status == ST_FULL, out_item.is_full)
  `IRD_ASSERT_IMP(a_empty_ends, out_strobe && out_item.is_empty, ends_neg)

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ird_pkg::*;

  // Opcode 3 is unused by the block and must act as a no-op.
  localparam logic [1:0] FN_NOP = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  ird_in_t             in_item;
  logic                out_strobe;
  ird_out_t            out_item;
  logic                cfg_we;
  logic [CAP_W-1:0]    cfg_wdata;

  // Model of the deque state, kept in step with accepted transfers.
  logic signed [WORD_W-1:0] ring_q [DEPTH];
  logic [PTR_W-1:0]         head_q;
  logic [CNT_W-1:0]         occ_q;
  logic [CAP_W-1:0]         cap_q;

  ird_out_t pending_q [$];
  int       err_count;

  input_restricted_deque u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    if (err_count < 50) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s got %h expected %h", name, got, want));
    end
  endtask

  function automatic ird_out_t predict_deque_step(input ird_in_t it);
    ird_out_t r;
    int       lim;
    int       occ;
    int       head;
    lim  = (int'(cap_q) > DEPTH) ? DEPTH : int'(cap_q);
    occ  = int'(occ_q);
    head = int'(head_q);
    r.popped = NEG_ONE;
    r.status = ST_DONE;
    case (it.func)
      FN_INSERT: begin
        if (occ >= lim) begin
          r.status = ST_FULL;
        end else begin
          ring_q[PTR_W'((head + occ) % DEPTH)] = it.value;
          occ++;
        end
      end
      FN_POP_FRONT: begin
        if (occ == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped = ring_q[PTR_W'(head)];
          head = (head + 1) % DEPTH;
          occ--;
        end
      end
      FN_POP_REAR: begin
        if (occ == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped = ring_q[PTR_W'((head + occ - 1) % DEPTH)];
          occ--;
        end
      end
      default: ;
    endcase
    r.is_full  = (occ >= lim);
    r.is_empty = (occ == 0);
    if (occ == 0) begin
      r.front_value = NEG_ONE;
      r.rear_value  = NEG_ONE;
    end else begin
      r.front_value = ring_q[PTR_W'(head)];
      r.rear_value  = ring_q[PTR_W'((head + occ - 1) % DEPTH)];
    end
    occ_q  = CNT_W'(occ);
    head_q = PTR_W'(head);
    return r;
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(9, 30);
  endfunction

  // One input transfer: idle for the given gap, then hold start until accepted.
  task automatic send_op(input logic [1:0] fn, input logic [WORD_W-1:0] val,
                         input int gap);
    ird_in_t it;
    it.func  = fn;
    it.value = val;
    @(posedge clk);
    repeat (gap) @(posedge clk);
    in_item <= it;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    pending_q.push_back(predict_deque_step(it));
  endtask

  // Write capacity only once every result is back and the block is idle.
  task automatic write_capacity(input logic [CAP_W-1:0] val);
    while (pending_q.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    cap_q = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_empty_queue();
    send_op(FN_POP_FRONT, 32'h1234_5678, 0);
    send_op(FN_POP_REAR, 32'hFFFF_FFFF, 1);
    send_op(FN_NOP, 32'h0000_0000, 0);
  endtask

  task automatic test_value_extremes();
    send_op(FN_INSERT, 32'h8000_0000, 0);
    send_op(FN_INSERT, 32'h7FFF_FFFF, 2);
    send_op(FN_INSERT, 32'h0000_0000, 0);
    send_op(FN_INSERT, 32'hFFFF_FFFF, 3);
    send_op(FN_INSERT, 32'h5555_5555, 0);
    send_op(FN_INSERT, 32'hAAAA_AAAA, 1);
    send_op(FN_POP_REAR, 32'h0, 0);
    send_op(FN_POP_FRONT, 32'h0, 0);
    send_op(FN_NOP, 32'hDEAD_BEEF, 5);
    send_op(FN_POP_FRONT, 32'h0, 0);
    send_op(FN_POP_REAR, 32'h0, 0);
    send_op(FN_POP_FRONT, 32'h0, 2);
    send_op(FN_POP_REAR, 32'h0, 0);
  endtask

  task automatic test_capacity_limits();
    // Zero capacity refuses every insert.
    write_capacity(5'd0);
    send_op(FN_INSERT, 32'h0BAD_0BAD, 0);
    write_capacity(5'd2);
    send_op(FN_INSERT, 32'h0000_0011, 0);
    send_op(FN_INSERT, 32'h0000_0022, 0);
    send_op(FN_INSERT, 32'h0000_0033, 0);
    // Capacity dropped below occupancy: stay full, keep entries, allow pops.
    write_capacity(5'd1);
    send_op(FN_INSERT, 32'h0000_0044, 0);
    send_op(FN_POP_FRONT, 32'h0, 1);
    send_op(FN_POP_REAR, 32'h0, 0);
    send_op(FN_POP_REAR, 32'h0, 0);
  endtask

  task automatic run_random_phase(input logic [CAP_W-1:0] cap, input int n_items);
    int               done;
    int               mode;
    int               len;
    int               r;
    bit               calm;
    logic [1:0]       fn;
    logic [WORD_W-1:0] val;
    write_capacity(cap);
    done = 0;
    while (done < n_items) begin
      // Bursts biased toward filling, draining, or mixed traffic.
      mode = $urandom_range(0, 2);
      len  = $urandom_range(4, 20);
      calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len && done < n_items; k++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          fn = FN_NOP;
        end else if (mode == 0) begin
          fn = (r < 80) ? FN_INSERT : ((r < 90) ? FN_POP_FRONT : FN_POP_REAR);
        end else if (mode == 1) begin
          fn = (r < 20) ? FN_INSERT : ((r < 60) ? FN_POP_FRONT : FN_POP_REAR);
        end else begin
          fn = (r < 40) ? FN_INSERT : ((r < 70) ? FN_POP_FRONT : FN_POP_REAR);
        end
        case ($urandom_range(0, 19))
          0:       val = 32'h8000_0000;
          1:       val = 32'h7FFF_FFFF;
          2:       val = 32'hFFFF_FFFF;
          3:       val = 32'h0000_0000;
          default: val = $urandom;
        endcase
        send_op(fn, val, calm ? 0 : rand_gap());
        if (fn != FN_NOP) done++;
      end
    end
  endtask

  task automatic test_random_traffic();
    logic [CAP_W-1:0] caps [9];
    caps = '{5'd16, 5'd31, 5'd3, 5'd0, 5'd1, 5'd9, 5'd24, 5'd15, 5'd0};
    caps[8] = CAP_W'($urandom_range(0, 31));
    foreach (caps[i]) begin
      run_random_phase(caps[i], 66);
    end
  endtask

  always @(posedge clk) begin : result_check
    ird_out_t want;
    if (rst_n && out_strobe) begin
      if (pending_q.size() == 0) begin
        flag_mismatch("result transfer with no pending expectation");
      end else begin
        want = pending_q.pop_front();
        check_field("popped", out_item.popped, want.popped);
        check_field("status", 32'(out_item.status), 32'(want.status));
        check_field("is_full", 32'(out_item.is_full), 32'(want.is_full));
        check_field("is_empty", 32'(out_item.is_empty), 32'(want.is_empty));
        check_field("front_value", out_item.front_value, want.front_value);
        check_field("rear_value", out_item.rear_value, want.rear_value);
      end
    end
  end

  initial begin
    int guard;
    clk       = 1'b0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    err_count = 0;
    head_q    = '0;
    occ_q     = '0;
    cap_q     = CAP_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_value_extremes();
    test_capacity_limits();
    test_random_traffic();

    guard = 0;
    while (pending_q.size() != 0 && guard < 200) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (pending_q.size() != 0) begin
      flag_mismatch($sformatf("%0d expected results never arrived", pending_q.size()));
    end
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout waiting for the deque to finish");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
